// ===== sv/imuca_pkg.sv =====
`default_nettype none

package imuca_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT   = 2'd1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd5120;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd62415;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

  // Arctangent table: degrees with TABLE_BITS fraction bits.
  localparam int TABLE_BITS = 20;
  localparam int TABLE_LEN  = 24;
  localparam int ITER_W     = 5;
  localparam int Z_W        = 30;
  localparam int CORDIC_W   = 33;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_GX,
    OP_INC_X,
    OP_INC_Y,
    OP_INC_Z,
    OP_INIT,
    OP_ITER,
    OP_ROUND,
    OP_DIFF,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_ACC,
    OP_SAT,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              axis;   // 0: pitch, 1: roll
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 30'sd47185920;
      5'd1:  v = 30'sd27855475;
      5'd2:  v = 30'sd14718068;
      5'd3:  v = 30'sd7471121;
      5'd4:  v = 30'sd3750058;
      5'd5:  v = 30'sd1876857;
      5'd6:  v = 30'sd938658;
      5'd7:  v = 30'sd469357;
      5'd8:  v = 30'sd234682;
      5'd9:  v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/imuca_ctrl.sv =====
`default_nettype none

module imuca_ctrl #(
  parameter int ATAN_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire imuca_pkg::status_t status,
  output imuca_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_INC_X,
    ST_INC_Y,
    ST_INC_Z,
    ST_INIT,
    ST_ITER,
    ST_ROUND,
    ST_DIFF,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACC,
    ST_SAT,
    ST_COMMIT
  } state_t;

  localparam logic [imuca_pkg::ITER_W-1:0] LAST_ITER =
    imuca_pkg::ITER_W'(ATAN_ITERATIONS - 1);

  state_t                         state_r, state_nxt;
  logic                           axis_r, axis_nxt;
  logic [imuca_pkg::ITER_W-1:0]   iter_r, iter_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    iter_nxt  = iter_r;
    cmd.op    = imuca_pkg::OP_NOP;
    cmd.axis  = axis_r;
    cmd.iter  = iter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = imuca_pkg::OP_LOAD;
          axis_nxt  = 1'b0;
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.op    = imuca_pkg::OP_MUL_GX;
        state_nxt = ST_INC_X;
      end
      ST_INC_X: begin
        cmd.op    = imuca_pkg::OP_INC_X;
        state_nxt = ST_INC_Y;
      end
      ST_INC_Y: begin
        cmd.op    = imuca_pkg::OP_INC_Y;
        state_nxt = ST_INC_Z;
      end
      ST_INC_Z: begin
        cmd.op    = imuca_pkg::OP_INC_Z;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.op    = imuca_pkg::OP_INIT;
        iter_nxt  = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.op = imuca_pkg::OP_ITER;
        if (iter_r == LAST_ITER) begin
          state_nxt = ST_ROUND;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.op    = imuca_pkg::OP_ROUND;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op    = imuca_pkg::OP_DIFF;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op    = imuca_pkg::OP_MUL_HI;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.op    = imuca_pkg::OP_MUL_LO;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = imuca_pkg::OP_ACC;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        cmd.op = imuca_pkg::OP_SAT;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_INIT;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The new angles replace the output registers only once the last
        // result has been taken.
        if (status.out_free) begin
          cmd.op    = imuca_pkg::OP_COMMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/imuca_datapath.sv =====
`default_nettype none

module imuca_datapath #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire imuca_pkg::cmd_t                       cmd,
  output imuca_pkg::status_t                         status,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_accel_x,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_accel_y,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_accel_z,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_gyro_x,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_gyro_y,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_gyro_z,
  input  wire logic                                  cfg_valid,
  input  wire logic [imuca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [imuca_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [imuca_pkg::ANGLE_W-1:0]       out_yaw_out,
  output logic signed [imuca_pkg::ANGLE_W-1:0]       out_pitch_out,
  output logic signed [imuca_pkg::ANGLE_W-1:0]       out_roll_out
);

  localparam int CW = imuca_pkg::CORDIC_W;
  localparam int ZW = imuca_pkg::Z_W;
  localparam int AW = imuca_pkg::ANGLE_W;
  localparam int RND_SHL = (ANGLE_FRAC_BITS >= imuca_pkg::TABLE_BITS) ?
                           ANGLE_FRAC_BITS - imuca_pkg::TABLE_BITS : 0;
  localparam int RND_SHR = (ANGLE_FRAC_BITS < imuca_pkg::TABLE_BITS) ?
                           imuca_pkg::TABLE_BITS - ANGLE_FRAC_BITS : 0;
  localparam int RND_HALF = (RND_SHR > 0) ? (1 << (RND_SHR - 1)) : 0;
  localparam logic signed [ZW-1:0] Z_90 = ZW'(90 << imuca_pkg::TABLE_BITS);

  logic signed [imuca_pkg::SAMPLE_W-1:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic [imuca_pkg::GAIN_W-1:0]          gain_r;
  logic [imuca_pkg::WEIGHT_W-1:0]        weight_r;
  logic [imuca_pkg::WEIGHT_W-1:0]        w_eff;

  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_r;
  logic signed [35:0] inc;

  logic signed [32:0] pitch_g_r, roll_g_r;
  logic signed [AW-1:0] yaw_new_r, pitch_new_r, roll_new_r;
  logic signed [AW-1:0] yaw_r, pitch_r, roll_r;
  logic                 out_valid_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic                 zero_r;
  logic signed [AW-1:0] a_r;
  logic signed [33:0]   d_r;
  logic signed [51:0]   acc_r;

  logic signed [imuca_pkg::SAMPLE_W-1:0] y_raw;
  logic signed [CW-1:0] x0, y0, dx, dy;
  logic signed [ZW-1:0] t_i;
  logic signed [AW-1:0] z_ext, z_rnd;
  logic signed [32:0]   g_sel;

  assign w_eff = (weight_r > imuca_pkg::WEIGHT_ONE) ? imuca_pkg::WEIGHT_ONE : weight_r;

  assign y_raw = cmd.axis ? ax_r : ay_r;
  assign x0    = CW'(az_r) <<< 14;
  assign y0    = CW'(y_raw) <<< 14;
  assign dx    = cy_r >>> cmd.iter;
  assign dy    = cx_r >>> cmd.iter;
  assign t_i   = imuca_pkg::atan_entry(cmd.iter);
  assign inc   = (prod_r + 36'sd128) >>> 8;
  assign z_ext = AW'(cz_r);
  assign z_rnd = ((z_ext + AW'(RND_HALF)) >>> RND_SHR) <<< RND_SHL;
  assign g_sel = cmd.axis ? roll_g_r : pitch_g_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      imuca_pkg::OP_MUL_GX: begin
        mul_a = 18'(gx_r);
        mul_b = $signed({2'b00, gain_r});
      end
      imuca_pkg::OP_INC_X: begin
        mul_a = 18'(gy_r);
        mul_b = $signed({2'b00, gain_r});
      end
      imuca_pkg::OP_INC_Y: begin
        mul_a = 18'(gz_r);
        mul_b = $signed({2'b00, gain_r});
      end
      imuca_pkg::OP_MUL_HI: begin
        mul_a = $signed(d_r[33:16]);
        mul_b = $signed({1'b0, w_eff});
      end
      imuca_pkg::OP_MUL_LO: begin
        mul_a = $signed({2'b00, d_r[15:0]});
        mul_b = $signed({1'b0, w_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= imuca_pkg::GAIN_RESET;
      weight_r <= imuca_pkg::WEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == imuca_pkg::REG_GYRO_STEP_GAIN) begin
        gain_r <= cfg_data[imuca_pkg::GAIN_W-1:0];
      end else if (cfg_index == imuca_pkg::REG_BLEND_WEIGHT) begin
        weight_r <= cfg_data;
      end
    end
  end

  // Working registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      imuca_pkg::OP_LOAD: begin
        ax_r <= in_accel_x;
        ay_r <= in_accel_y;
        az_r <= in_accel_z;
        gx_r <= in_gyro_x;
        gy_r <= in_gyro_y;
        gz_r <= in_gyro_z;
      end
      imuca_pkg::OP_INC_X: begin
        pitch_g_r <= 33'(36'(pitch_r) + inc);
      end
      imuca_pkg::OP_INC_Y: begin
        roll_g_r <= 33'(36'(roll_r) - inc);
      end
      imuca_pkg::OP_INC_Z: begin
        yaw_new_r <= imuca_pkg::sat32(36'(yaw_r) + inc);
      end
      imuca_pkg::OP_INIT: begin
        zero_r <= (az_r == '0) && (y_raw == '0);
        // A vector in the left half plane is first turned by a quarter turn.
        if (az_r < 0) begin
          if (y_raw >= 0) begin
            cx_r <= y0;
            cy_r <= -x0;
            cz_r <= Z_90;
          end else begin
            cx_r <= -y0;
            cy_r <= x0;
            cz_r <= -Z_90;
          end
        end else begin
          cx_r <= x0;
          cy_r <= y0;
          cz_r <= '0;
        end
      end
      imuca_pkg::OP_ITER: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + t_i;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - t_i;
        end
      end
      imuca_pkg::OP_ROUND: begin
        a_r <= zero_r ? '0 : z_rnd;
      end
      imuca_pkg::OP_DIFF: begin
        d_r <= 34'(g_sel) - 34'(a_r);
      end
      imuca_pkg::OP_MUL_LO: begin
        // w*g + (1-w)*a is formed as w*(g-a) + a, scaled by 2^16.
        acc_r <= (52'(prod_r) <<< 16) + (52'(a_r) <<< 16) + 52'sd32768;
      end
      imuca_pkg::OP_ACC: begin
        acc_r <= acc_r + 52'(prod_r);
      end
      imuca_pkg::OP_SAT: begin
        if (cmd.axis) begin
          roll_new_r <= imuca_pkg::sat32(acc_r[51:16]);
        end else begin
          pitch_new_r <= imuca_pkg::sat32(acc_r[51:16]);
        end
      end
      default: begin
      end
    endcase
  end

  // The output registers are also the filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r       <= '0;
      pitch_r     <= '0;
      roll_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.op == imuca_pkg::OP_COMMIT) begin
      yaw_r       <= yaw_new_r;
      pitch_r     <= pitch_new_r;
      roll_r      <= roll_new_r;
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_yaw_out     = yaw_r;
  assign out_pitch_out   = pitch_r;
  assign out_roll_out    = roll_r;

endmodule

`default_nettype wire

// ===== sv/imu_complementary_attitude.sv =====
// Complementary-filter attitude estimator.
// Input channel (in_valid/in_ready): one raw six-axis sample per transfer,
// three signed 16-bit accelerometer axes and three gyro axes.
// Output channel (out_valid/out_ready): yaw, pitch and roll after the update,
// signed degrees with ANGLE_FRAC_BITS fraction bits; one result per sample.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 is the
// gyro step gain, index 1 the blend weight; other indexes are ignored.
// Write it only while no sample is in flight.
// Only one sample is in flight at a time: a new sample is taken only after
// the previous one has been committed. The time per sample is set by the
// shared CORDIC stage, which runs its iterations for pitch and then for
// roll, and by the single 18x18 multiplier used for gyro scaling and the
// blends.
// Reset clears the angles to zero, loads the register defaults and drops
// out_valid. A stalled receiver holds the result; the next sample is still
// taken and computed, and waits before its commit until the held result
// has been transferred.
`default_nettype none

module imu_complementary_attitude #(
  parameter int ATAN_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_accel_x,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_accel_y,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_accel_z,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_gyro_x,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_gyro_y,
  input  wire logic signed [imuca_pkg::SAMPLE_W-1:0] in_gyro_z,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [imuca_pkg::ANGLE_W-1:0]       out_yaw_out,
  output logic signed [imuca_pkg::ANGLE_W-1:0]       out_pitch_out,
  output logic signed [imuca_pkg::ANGLE_W-1:0]       out_roll_out,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [imuca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [imuca_pkg::CFG_DATA_W-1:0]      cfg_data
);

  imuca_pkg::cmd_t    cmd;
  imuca_pkg::status_t status;

  assign cfg_ready = 1'b1;

  imuca_ctrl #(
    .ATAN_ITERATIONS(ATAN_ITERATIONS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  imuca_datapath #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_accel_x   (in_accel_x),
    .in_accel_y   (in_accel_y),
    .in_accel_z   (in_accel_z),
    .in_gyro_x    (in_gyro_x),
    .in_gyro_y    (in_gyro_y),
    .in_gyro_z    (in_gyro_z),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_yaw_out  (out_yaw_out),
    .out_pitch_out(out_pitch_out),
    .out_roll_out (out_roll_out)
  );

endmodule

`default_nettype wire

// ===== sv/imuca_checker.sv =====
`default_nettype none

module imuca_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_yaw_out,
  input wire logic [31:0] out_pitch_out,
  input wire logic [31:0] out_roll_out
);

  // A held result keeps its value until it is transferred.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_yaw_out)
      && $stable(out_pitch_out) && $stable(out_roll_out))
    else $error("held result changed before its transfer");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The block works on one sample at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in flight");

  // A new result is never committed in the cycle the previous one leaves.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated or replaced without a gap");

endmodule

bind imu_complementary_attitude imuca_checker u_imuca_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_yaw_out  (out_yaw_out),
  .out_pitch_out(out_pitch_out),
  .out_roll_out (out_roll_out)
);

`default_nettype wire
